@@ src/pdg_pkg.sv @@
// Shared types, constants and the dither table for the plasma dither byte generator.
`default_nettype none
package pdg_pkg;

    // Item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_GEN  = 1'b1;

    // Configuration register indexes
    localparam int         CFG_IDX_W      = 2;
    localparam logic [1:0] CFG_ROW_BYTES  = 2'd0;
    localparam logic [1:0] CFG_ROW_COUNT  = 2'd1;
    localparam logic [1:0] CFG_PALE_BANDS = 2'd2;

    localparam logic [6:0] ROW_BYTES_RST  = 7'd20;
    localparam logic [8:0] ROW_COUNT_RST  = 9'd168;
    localparam logic       PALE_BANDS_RST = 1'b1;

    localparam int SINE_ENTRIES  = 256;
    localparam int SINE_W        = 8;
    localparam int DITHER_LEVELS = 33;
    localparam int LEVEL_W       = $clog2(DITHER_LEVELS);
    localparam int PHASE_W       = 16;
    localparam int PHASE_MOD     = 65536;

    localparam logic [6:0] MAX_ROW_BYTES = 7'd64;
    localparam logic [8:0] MAX_ROWS      = 9'd256;

    localparam int PHASE_SCALE = 20;
    localparam int DRIFT_SPEED = 13;
    localparam int PIXEL_MUL_A = 47;
    localparam int PIXEL_MUL_B = 26;

    localparam logic [PHASE_W-1:0] ROW_INC_A = PHASE_W'(PHASE_SCALE * 9);
    localparam logic [PHASE_W-1:0] ROW_INC_B = PHASE_W'(PHASE_SCALE * 33);
    localparam logic [PHASE_W-1:0] FRAME_XA_INC = PHASE_W'(DRIFT_SPEED * 77);
    localparam logic [PHASE_W-1:0] FRAME_YA_INC = PHASE_W'(DRIFT_SPEED * 93);
    localparam logic [PHASE_W-1:0] FRAME_XB_INC = PHASE_W'(PHASE_MOD - DRIFT_SPEED * 12);
    localparam logic [PHASE_W-1:0] FRAME_YB_INC = PHASE_W'(DRIFT_SPEED * 17);

    localparam logic [LEVEL_W-1:0] LEVEL_PALE_BASE = LEVEL_W'(18);
    localparam logic [LEVEL_W-1:0] LEVEL_DARK_BASE = LEVEL_W'(2);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Band to dither code, bit-reversed order; entry 0 is the rightmost
    typedef logic [7:0][2:0] band_order_t;
    localparam band_order_t BAND_ORDER =
        {3'd7, 3'd3, 3'd5, 3'd1, 3'd6, 3'd2, 3'd4, 3'd0};

    typedef logic [3:0][7:0] dither_entry_t;
    typedef dither_entry_t [DITHER_LEVELS-1:0] dither_rom_t;

    // Each level adds one dot to the previous level's 4x8 pattern
    function automatic dither_rom_t build_dither();
        dither_rom_t rom;
        logic [4:0]  k;
        logic [2:0]  cx;
        logic [1:0]  cy;
        rom = '0;
        for (int lv = 1; lv < DITHER_LEVELS; lv++)
        begin
            k = 5'(lv - 1);
            cx = {k[0], k[2], k[4]};
            cy = {k[1], k[3]};
            rom[lv] = rom[lv-1];
            cx = cx ^ {1'b0, cy};
            rom[lv][cy] = rom[lv][cy] | (8'd1 << cx);
        end
        return rom;
    endfunction

    localparam dither_rom_t DITHER_ROM = build_dither();

    // One queued item between front and back
    typedef struct packed {
        logic               gen;
        logic [7:0]         load_index;
        logic [SINE_W-1:0]  load_value;
        logic [7:0]         row_addr_a;
        logic [7:0]         row_addr_b;
        logic [PHASE_W-1:0] pix_a;
        logic [PHASE_W-1:0] pix_b;
        logic [7:0]         row;
        logic [5:0]         col;
        logic               last;
    } cmd_t;

    typedef struct packed {
        logic gen_push;
        logic last_frame;
        logic at_origin;
    } fe_status_t;

    typedef struct packed {
        logic busy;
        logic ram_we;
    } bk_status_t;

endpackage
`default_nettype wire

@@ src/plasma_dither_byte_generator.sv @@
// Top level of the plasma dither byte generator: config registers, front, queue, back.
//
// Input channel (in_valid/in_stall): op selects a sine table load (sine_index,
// sine_value) or a request for the next framebuffer byte. Loads give no result.
// Output channel (out_valid/out_stall): one item per byte request, carrying
// pixel_byte, row_index, byte_index and frame_end, in request order.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): row_bytes, row_count,
// pale_bands; cfg_ready is always high. Write only while the block is idle.
// The front end takes one item per cycle into a 4-entry queue while the queue is
// not full, stepping the frame, row and pixel phases itself. The back end handles
// a load as it pops it and works through a byte request slice by slice, paced by
// the two read ports of the sine table RAM, and can take the next item as it
// finishes a byte. Reset clears the front end phases and all counters and restores
// the register defaults; the sine table is not cleared and must be loaded before
// bytes are requested. A stalled result is held in the output register while the
// back end works on the next item and the queue keeps filling; in_stall rises
// when it is full.
`default_nettype none
module plasma_dither_byte_generator import pdg_pkg::*; #(
    parameter int PIXELS_PER_SLICE = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 op,
    input  wire logic [7:0]           sine_index,
    input  wire logic signed [7:0]    sine_value,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                pixel_byte,
    output logic [7:0]                row_index,
    output logic [5:0]                byte_index,
    output logic                      frame_end,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [8:0]           cfg_data
);

    logic [6:0] row_bytes_reg;
    logic [8:0] row_count_reg;
    logic       pale_bands_reg;

    logic       push, pop, q_full, q_empty;
    cmd_t       push_cmd, head;
    fe_status_t fe_status;
    bk_status_t bk_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg  <= ROW_BYTES_RST;
            row_count_reg  <= ROW_COUNT_RST;
            pale_bands_reg <= PALE_BANDS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROW_BYTES:  row_bytes_reg  <= cfg_data[6:0];
                CFG_ROW_COUNT:  row_count_reg  <= cfg_data;
                CFG_PALE_BANDS: pale_bands_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    pdg_front #(
        .PIXELS_PER_SLICE (PIXELS_PER_SLICE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .sine_index (sine_index),
        .sine_value (sine_value),
        .row_bytes  (row_bytes_reg),
        .row_count  (row_count_reg),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd),
        .status     (fe_status)
    );

    pdg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    pdg_back #(
        .PIXELS_PER_SLICE (PIXELS_PER_SLICE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head       (head),
        .pop        (pop),
        .pale_bands (pale_bands_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_byte (pixel_byte),
        .row_index  (row_index),
        .byte_index (byte_index),
        .frame_end  (frame_end),
        .status     (bk_status)
    );

    // The last byte of a frame sends the counters back to the top left
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        fe_status.gen_push && fe_status.last_frame |=> fe_status.at_origin)
        else $error("counters did not wrap at frame end");

    // A table load only happens when the back end is free or finishing, and leaves it free
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.ram_we |=> !bk_status.busy)
        else $error("back end busy after a table load");

    // Never pop an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty && !(q_full && q_empty))
        else $error("queue popped while empty");

endmodule
`default_nettype wire

@@ src/pdg_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none
module pdg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem_reg[raddr_a];
            rdata_b <= mem_reg[raddr_b];
        end
    end

endmodule
`default_nettype wire

@@ src/pdg_front.sv @@
// Front end: accepts items, tracks phases and counters, queues commands.
`default_nettype none
module pdg_front import pdg_pkg::*; #(
    parameter int PIXELS_PER_SLICE = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              op,
    input  wire logic [7:0]        sine_index,
    input  wire logic [SINE_W-1:0] sine_value,
    input  wire logic [6:0]        row_bytes,
    input  wire logic [8:0]        row_count,
    input  wire logic              q_full,
    output logic                   push,
    output cmd_t                   push_cmd,
    output fe_status_t             status
);

    localparam int NSLICE    = (8 + PIXELS_PER_SLICE - 1) / PIXELS_PER_SLICE;
    localparam int PIX_INC_A = PHASE_SCALE * PIXELS_PER_SLICE * PIXEL_MUL_A;
    localparam int PIX_INC_B = PHASE_SCALE * PIXELS_PER_SLICE * PIXEL_MUL_B;
    localparam logic [PHASE_W-1:0] PIX_ADV_A = PHASE_W'((NSLICE * PIX_INC_A) % PHASE_MOD);
    localparam logic [PHASE_W-1:0] PIX_ADV_B = PHASE_W'((NSLICE * PIX_INC_B) % PHASE_MOD);

    logic [PHASE_W-1:0] fxa_reg, fxb_reg, fya_reg, fyb_reg;
    logic [PHASE_W-1:0] rowa_reg, rowb_reg, pixa_reg, pixb_reg;
    logic [7:0]         row_cnt_reg;
    logic [5:0]         byte_cnt_reg;

    logic [PHASE_W-1:0] fxa_next, fxb_next, fya_next, fyb_next;
    logic [PHASE_W-1:0] rowa_next, rowb_next, pixa_next, pixb_next;
    logic [7:0]         row_cnt_next;
    logic [5:0]         byte_cnt_next;

    logic [6:0] stride;
    logic [8:0] rows;
    logic       last_row;
    logic       last_frame;
    logic       gen_push;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    assign gen_push = push && (op == OP_GEN);

    always_comb
    begin
        if (row_bytes == 7'd0)
        begin
            stride = 7'd1;
        end
        else if (row_bytes > MAX_ROW_BYTES)
        begin
            stride = MAX_ROW_BYTES;
        end
        else
        begin
            stride = row_bytes;
        end
        if (row_count == 9'd0)
        begin
            rows = 9'd1;
        end
        else if (row_count > MAX_ROWS)
        begin
            rows = MAX_ROWS;
        end
        else
        begin
            rows = row_count;
        end
    end

    assign last_row   = ({1'b0, byte_cnt_reg} + 7'd1) >= stride;
    assign last_frame = last_row && (({1'b0, row_cnt_reg} + 9'd1) >= rows);

    always_comb
    begin
        push_cmd.gen        = (op == OP_GEN);
        push_cmd.load_index = sine_index;
        push_cmd.load_value = sine_value;
        push_cmd.row_addr_a = rowa_reg[PHASE_W-1 -: 8];
        push_cmd.row_addr_b = rowb_reg[PHASE_W-1 -: 8];
        push_cmd.pix_a      = pixa_reg;
        push_cmd.pix_b      = pixb_reg;
        push_cmd.row        = row_cnt_reg;
        push_cmd.col        = byte_cnt_reg;
        push_cmd.last       = last_frame;
    end

    always_comb
    begin
        fxa_next      = fxa_reg;
        fxb_next      = fxb_reg;
        fya_next      = fya_reg;
        fyb_next      = fyb_reg;
        rowa_next     = rowa_reg;
        rowb_next     = rowb_reg;
        pixa_next     = pixa_reg;
        pixb_next     = pixb_reg;
        row_cnt_next  = row_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        if (gen_push)
        begin
            if (!last_row)
            begin
                byte_cnt_next = byte_cnt_reg + 6'd1;
                pixa_next     = pixa_reg + PIX_ADV_A;
                pixb_next     = pixb_reg + PIX_ADV_B;
            end
            else if (!last_frame)
            begin
                byte_cnt_next = 6'd0;
                row_cnt_next  = row_cnt_reg + 8'd1;
                rowa_next     = rowa_reg + ROW_INC_A;
                rowb_next     = rowb_reg + ROW_INC_B;
                pixa_next     = fxa_reg;
                pixb_next     = fxb_reg;
            end
            else
            begin
                // Advance the frame phases and restart from the top left
                byte_cnt_next = 6'd0;
                row_cnt_next  = 8'd0;
                fxa_next      = fxa_reg + FRAME_XA_INC;
                fya_next      = fya_reg + FRAME_YA_INC;
                fxb_next      = fxb_reg + FRAME_XB_INC;
                fyb_next      = fyb_reg + FRAME_YB_INC;
                rowa_next     = fya_next;
                rowb_next     = fyb_next;
                pixa_next     = fxa_next;
                pixb_next     = fxb_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fxa_reg      <= '0;
            fxb_reg      <= '0;
            fya_reg      <= '0;
            fyb_reg      <= '0;
            rowa_reg     <= '0;
            rowb_reg     <= '0;
            pixa_reg     <= '0;
            pixb_reg     <= '0;
            row_cnt_reg  <= '0;
            byte_cnt_reg <= '0;
        end
        else
        begin
            fxa_reg      <= fxa_next;
            fxb_reg      <= fxb_next;
            fya_reg      <= fya_next;
            fyb_reg      <= fyb_next;
            rowa_reg     <= rowa_next;
            rowb_reg     <= rowb_next;
            pixa_reg     <= pixa_next;
            pixb_reg     <= pixb_next;
            row_cnt_reg  <= row_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
        end
    end

    assign status.gen_push   = gen_push;
    assign status.last_frame = last_frame;
    assign status.at_origin  = (row_cnt_reg == 8'd0) && (byte_cnt_reg == 6'd0);

endmodule
`default_nettype wire

@@ src/pdg_queue.sv @@
// Short command queue between the front end and the back end.
`default_nettype none
module pdg_queue import pdg_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output logic      full,
    output logic      empty
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ src/pdg_back.sv @@
// Back end: sine table, per-slice sample sums, dithering and the output register.
`default_nettype none
module pdg_back import pdg_pkg::*; #(
    parameter int PIXELS_PER_SLICE = 2
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire cmd_t head,
    output logic      pop,
    input  wire logic pale_bands,
    output logic      out_valid,
    input  wire logic out_stall,
    output logic [7:0] pixel_byte,
    output logic [7:0] row_index,
    output logic [5:0] byte_index,
    output logic       frame_end,
    output bk_status_t status
);

    localparam int NSLICE = (8 + PIXELS_PER_SLICE - 1) / PIXELS_PER_SLICE;
    localparam int SW     = $clog2(NSLICE + 1);
    localparam logic [PHASE_W-1:0] PIX_INC_A =
        PHASE_W'((PHASE_SCALE * PIXELS_PER_SLICE * PIXEL_MUL_A) % PHASE_MOD);
    localparam logic [PHASE_W-1:0] PIX_INC_B =
        PHASE_W'((PHASE_SCALE * PIXELS_PER_SLICE * PIXEL_MUL_B) % PHASE_MOD);
    localparam logic [15:0] BASE_MASK = 16'((1 << PIXELS_PER_SLICE) - 1);

    logic               busy_reg;
    logic [SW-1:0]      step_reg;
    cmd_t               cmd_reg;
    logic [PHASE_W-1:0] pa_reg, pb_reg;
    logic [8:0]         rowsum_reg;
    logic [7:0]         buf_reg;
    logic               out_valid_reg;
    logic [7:0]         pixel_byte_reg;
    logic [7:0]         row_index_reg;
    logic [5:0]         byte_index_reg;
    logic               frame_end_reg;

    logic               ram_we, ram_re;
    logic [7:0]         raddr_a, raddr_b;
    logic [SINE_W-1:0]  rd_a, rd_b;

    logic               last_step, finish, take;
    logic [SW-1:0]      slice_idx;
    logic [9:0]         sum;
    logic [2:0]         band, code;
    logic [LEVEL_W-1:0] level;
    logic [15:0]        wide_mask;
    logic [7:0]         contrib;

    assign last_step = busy_reg && (step_reg == SW'(NSLICE));
    assign finish    = last_step && (!out_valid_reg || !out_stall);
    assign take      = !busy_reg || finish;
    assign pop       = take && !q_empty;
    assign ram_we    = pop && (head.gen == OP_LOAD);

    always_comb
    begin
        ram_re  = 1'b0;
        raddr_a = head.row_addr_a;
        raddr_b = head.row_addr_b;
        if (pop && (head.gen == OP_GEN))
        begin
            ram_re = 1'b1;
        end
        else if (busy_reg && (step_reg < SW'(NSLICE)))
        begin
            ram_re  = 1'b1;
            raddr_a = pa_reg[PHASE_W-1 -: 8];
            raddr_b = pb_reg[PHASE_W-1 -: 8];
        end
    end

    pdg_ram #(
        .WIDTH (SINE_W),
        .DEPTH (SINE_ENTRIES)
    ) u_sine (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (head.load_index),
        .wdata   (head.load_value),
        .re      (ram_re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Slice sum, band, dither level and the slice's bits of the pattern row
    always_comb
    begin
        slice_idx = step_reg - 1'b1;
        sum       = {rowsum_reg[8], rowsum_reg} + {{2{rd_a[7]}}, rd_a} + {{2{rd_b[7]}}, rd_b};
        band      = {~sum[9], sum[8:7]};
        code      = BAND_ORDER[band];
        if (pale_bands)
        begin
            level = {2'b00, code, 1'b0} + LEVEL_PALE_BASE;
        end
        else
        begin
            level = {1'b0, code, 2'b00} + LEVEL_DARK_BASE;
        end
        wide_mask = BASE_MASK << (int'(slice_idx) * PIXELS_PER_SLICE);
        contrib   = DITHER_ROM[level][cmd_reg.row[1:0]] & wide_mask[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (pop && (head.gen == OP_GEN))
        begin
            cmd_reg <= head;
            pa_reg  <= head.pix_a;
            pb_reg  <= head.pix_b;
            buf_reg <= 8'd0;
        end
        else if (busy_reg && !last_step)
        begin
            if (step_reg == '0)
            begin
                rowsum_reg <= {rd_a[7], rd_a} + {rd_b[7], rd_b};
            end
            else
            begin
                buf_reg <= buf_reg | contrib;
            end
            pa_reg <= pa_reg + PIX_INC_A;
            pb_reg <= pb_reg + PIX_INC_B;
        end
        if (finish)
        begin
            pixel_byte_reg <= buf_reg | contrib;
            row_index_reg  <= cmd_reg.row;
            byte_index_reg <= cmd_reg.col;
            frame_end_reg  <= cmd_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && (head.gen == OP_GEN))
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg && !last_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_byte = pixel_byte_reg;
    assign row_index  = row_index_reg;
    assign byte_index = byte_index_reg;
    assign frame_end  = frame_end_reg;

    assign status.busy   = busy_reg;
    assign status.ram_we = ram_we;

endmodule
`default_nettype wire
